/* hw/rtl/epoch_seconds_to_calendar_macros.svh */
// Assertion macros shared by the calendar converter RTL.
// Each macro expects clk and rst to be visible where it is used.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Same-cycle implication, switched off while in reset.
`define ESC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar converter: same-cycle check failed");

// Next-cycle implication, switched off while in reset.
`define ESC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("calendar converter: next-cycle check failed");

`endif

/* hw/rtl/esc_pkg.sv */
// Shared types and constants for the epoch seconds to calendar converter.
// No dependencies.
`default_nettype none

package esc_pkg;

  localparam int NUM_STAGES = 6;

  // Stage control handed from the pipeline controller to the datapaths.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } pipe_ctrl_t;

  // secs / 86400 == (secs >> 7) / 675, done as multiply by 2^35/675 rounded up.
  localparam int          DAY_SHIFT     = 7;
  localparam int          DAY_K         = 35;
  localparam int          DAY_PROD_W    = 51;
  localparam logic [25:0] DAY_RECIP     = 26'd50903317;
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;

  // Day count from year zero, March based, at 1970-01-01.
  localparam logic [19:0] MARCH_EPOCH   = 20'd719468;
  localparam logic [19:0] CYC400_X4     = 20'd584388;
  localparam logic [19:0] CYC400_X5     = 20'd730485;
  localparam logic [17:0] DAYS_100Y     = 18'd36524;
  localparam logic [16:0] DAYS_4Y_RECIP = 17'd91868;   // 2^27 / 1461, rounded up
  localparam int          DAYS_4Y_K     = 27;
  localparam logic [15:0] DAYS_4Y       = 16'd1461;
  localparam logic [10:0] DAYS_1Y       = 11'd365;

  // Offset of each month in a year starting on March 1.
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };

  // Time of day.
  localparam logic [13:0] HOUR_RECIP = 14'd9321;   // 2^21 / 225, rounded up
  localparam int          HOUR_K     = 21;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;   // 2^14 / 15, rounded up
  localparam int          MIN_K      = 14;
  localparam logic [11:0] SECS_PER_MIN = 12'd60;

  // Weekday: (n + 1) mod 7 via multiply by 2^20/7 rounded up.
  localparam logic [17:0] WEEK_RECIP = 18'd149797;
  localparam int          WEEK_K     = 20;
  localparam logic [16:0] DAYS_PER_WEEK = 17'd7;

endpackage

`default_nettype wire

/* hw/rtl/esc_pipe_ctrl.sv */
// Valid bits and load enables for the six-stage converter pipeline.
// Depends on esc_pkg.
`default_nettype none

module esc_pipe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output esc_pkg::pipe_ctrl_t    ctrl
);

  logic [esc_pkg::NUM_STAGES-1:0] valid;
  logic [esc_pkg::NUM_STAGES-1:0] ready;

  // A stage takes new content when it is empty or its occupant moves on.
  always_comb begin
    ready[esc_pkg::NUM_STAGES-1] = !valid[esc_pkg::NUM_STAGES-1] || !out_stall;
    for (int i = esc_pkg::NUM_STAGES - 2; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) valid[0] <= in_valid;
      for (int i = 1; i < esc_pkg::NUM_STAGES; i++) begin
        if (ready[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign in_stall   = !ready[0];
  assign out_valid  = valid[esc_pkg::NUM_STAGES-1];
  assign ctrl.load  = ready;
  assign ctrl.valid = valid;

endmodule

`default_nettype wire

/* hw/rtl/esc_day_split.sv */
// Stages 1 and 2: split the seconds count into whole days and seconds of day.
// Depends on esc_pkg.
`default_nettype none

module esc_day_split (
  input  wire logic           clk,
  input  wire esc_pkg::pipe_ctrl_t ctrl,
  input  wire logic [31:0]    epoch_seconds,
  output logic [15:0]         day_num,
  output logic [16:0]         day_sec
);

  logic [31:0]                    s1_secs;
  logic [esc_pkg::DAY_PROD_W-1:0] s1_prod;
  logic [15:0]                    day_q;
  logic [16:0]                    dsec;

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      s1_secs <= epoch_seconds;
      s1_prod <= esc_pkg::DAY_PROD_W'(epoch_seconds[31:esc_pkg::DAY_SHIFT])
               * esc_pkg::DAY_PROD_W'(esc_pkg::DAY_RECIP);
    end
  end

  always_comb begin
    day_q = s1_prod[esc_pkg::DAY_K+15:esc_pkg::DAY_K];
    dsec  = 17'(s1_secs - 32'(day_q) * esc_pkg::SECS_PER_DAY);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      day_num <= day_q;
      day_sec <= dsec;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/esc_date.sv */
// Stages 3 to 6 of the date path: 400/100/4/1 year cycles, then month and day.
// Depends on esc_pkg.
`default_nettype none

module esc_date (
  input  wire logic           clk,
  input  wire esc_pkg::pipe_ctrl_t ctrl,
  input  wire logic [15:0]    day_num,
  output logic [11:0]         year,
  output logic [3:0]          month,
  output logic [4:0]          day_of_month
);

  // stage 3
  logic [19:0] d;
  logic        hi400;
  logic [17:0] r400;
  logic [1:0]  q100;
  logic [15:0] r100_c;
  logic [11:0] ybase_c;
  logic [15:0] s3_r100;
  logic [11:0] s3_ybase;
  // stage 4
  logic [32:0] s4_prod;
  logic [15:0] s4_r100;
  logic [11:0] s4_ybase;
  // stage 5
  logic [4:0]  q4;
  logic [10:0] r4;
  logic [1:0]  q1;
  logic [8:0]  doy_c;
  logic [11:0] yr_c;
  logic [8:0]  s5_doy;
  logic [11:0] s5_yr;
  // stage 6
  logic [3:0]  mi;
  logic [4:0]  dom_c;
  logic [3:0]  month_c;
  logic [11:0] year_c;

  // 400-year quotient is 4 or 5 across the whole 32-bit input range.
  always_comb begin
    d     = 20'(day_num) + esc_pkg::MARCH_EPOCH;
    hi400 = (d >= esc_pkg::CYC400_X5);
    r400  = 18'(d - (hi400 ? esc_pkg::CYC400_X5 : esc_pkg::CYC400_X4));
    priority if (r400 >= 18'(3 * esc_pkg::DAYS_100Y)) q100 = 2'd3;
    else if (r400 >= 18'(2 * esc_pkg::DAYS_100Y))     q100 = 2'd2;
    else if (r400 >= esc_pkg::DAYS_100Y)              q100 = 2'd1;
    else                                              q100 = 2'd0;
    r100_c  = 16'(r400 - 18'(q100) * esc_pkg::DAYS_100Y);
    ybase_c = (hi400 ? 12'd2000 : 12'd1600) + 12'(q100) * 12'd100;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_r100  <= r100_c;
      s3_ybase <= ybase_c;
    end
    if (ctrl.load[3]) begin
      s4_prod  <= 33'(s3_r100) * 33'(esc_pkg::DAYS_4Y_RECIP);
      s4_r100  <= s3_r100;
      s4_ybase <= s3_ybase;
    end
  end

  // Quotient of the 1-year step capped at 3 so a leap day stays in its year.
  always_comb begin
    q4 = s4_prod[esc_pkg::DAYS_4Y_K+4:esc_pkg::DAYS_4Y_K];
    r4 = 11'(s4_r100 - 16'(q4) * esc_pkg::DAYS_4Y);
    priority if (r4 >= 11'(3 * esc_pkg::DAYS_1Y)) q1 = 2'd3;
    else if (r4 >= 11'(2 * esc_pkg::DAYS_1Y))     q1 = 2'd2;
    else if (r4 >= esc_pkg::DAYS_1Y)              q1 = 2'd1;
    else                                          q1 = 2'd0;
    doy_c = 9'(r4 - 11'(q1) * esc_pkg::DAYS_1Y);
    yr_c  = s4_ybase + 12'(q4) * 12'd4 + 12'(q1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      s5_doy <= doy_c;
      s5_yr  <= yr_c;
    end
  end

  // Month index from March = number of month starts after March 1 at or before the day.
  always_comb begin
    mi = '0;
    for (int k = 1; k < 12; k++) begin
      mi = mi + 4'(s5_doy >= esc_pkg::MONTH_START[k]);
    end
    dom_c = 5'(s5_doy - esc_pkg::MONTH_START[mi] + 9'd1);
    if (mi >= 4'd10) begin
      month_c = mi - 4'd9;        // January, February: next civil year
      year_c  = s5_yr + 12'd1;
    end else begin
      month_c = mi + 4'd3;
      year_c  = s5_yr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      year         <= year_c;
      month        <= month_c;
      day_of_month <= dom_c;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/esc_time.sv */
// Stages 3 to 6 of the time path: hour, minute, second and weekday.
// Depends on esc_pkg.
`default_nettype none

module esc_time (
  input  wire logic           clk,
  input  wire esc_pkg::pipe_ctrl_t ctrl,
  input  wire logic [15:0]    day_num,
  input  wire logic [16:0]    day_sec,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic [5:0]          second,
  output logic [2:0]          weekday
);

  logic [16:0] wd_x;
  logic [26:0] s3_phr;
  logic [16:0] s3_dsec;
  logic [34:0] s3_pwd;
  logic [16:0] s3_wdx;

  logic [4:0]  hr_c;
  logic [11:0] rest_c;
  logic [14:0] q7;
  logic [2:0]  wd_c;
  logic [4:0]  s4_hr;
  logic [11:0] s4_rest;
  logic [2:0]  s4_wd;

  logic [20:0] s5_pmin;
  logic [11:0] s5_rest;
  logic [4:0]  s5_hr;
  logic [2:0]  s5_wd;

  logic [5:0]  min_c;
  logic [5:0]  sec_c;

  assign wd_x = 17'(day_num) + 17'd1;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      s3_phr  <= 27'(day_sec[16:4]) * 27'(esc_pkg::HOUR_RECIP);
      s3_dsec <= day_sec;
      s3_pwd  <= 35'(wd_x) * 35'(esc_pkg::WEEK_RECIP);
      s3_wdx  <= wd_x;
    end
  end

  always_comb begin
    hr_c   = s3_phr[esc_pkg::HOUR_K+4:esc_pkg::HOUR_K];
    rest_c = 12'(s3_dsec - 17'(hr_c) * esc_pkg::SECS_PER_HOUR);
    q7     = s3_pwd[esc_pkg::WEEK_K+14:esc_pkg::WEEK_K];
    wd_c   = 3'(s3_wdx - 17'(q7) * esc_pkg::DAYS_PER_WEEK) + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      s4_hr   <= hr_c;
      s4_rest <= rest_c;
      s4_wd   <= wd_c;
    end
    if (ctrl.load[4]) begin
      s5_pmin <= 21'(s4_rest[11:2]) * 21'(esc_pkg::MIN_RECIP);
      s5_rest <= s4_rest;
      s5_hr   <= s4_hr;
      s5_wd   <= s4_wd;
    end
  end

  always_comb begin
    min_c = s5_pmin[esc_pkg::MIN_K+5:esc_pkg::MIN_K];
    sec_c = 6'(s5_rest - 12'(min_c) * esc_pkg::SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      hour    <= s5_hr;
      minute  <= min_c;
      second  <= sec_c;
      weekday <= s5_wd;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/epoch_seconds_to_calendar.sv */
// Epoch seconds to calendar converter, top level.
// Depends on esc_pkg, esc_pipe_ctrl, esc_day_split, esc_date, esc_time and
// epoch_seconds_to_calendar_macros.svh.
// Usage:
//  - Input channel in_valid / in_stall carries one word: epoch_seconds, an
//    unsigned count of seconds since 1970-01-01 00:00:00. Any 32-bit value.
//  - Output channel out_valid / out_stall carries one word per input word:
//    year, month, day_of_month, hour, minute, second and weekday, where
//    1970-01-01 gives weekday 2.
//  - A word is taken on a rising edge with valid high and stall low.
//  - Depth: six register stages. A word accepted on a rising edge passes
//    through all six in order before it is presented with out_valid.
//  - Throughput: one word per cycle, sustained while out_stall is low.
//    Stage depth is set by the constant-reciprocal multiplies (days,
//    4-year cycle, hour, minute, weekday), each followed by a register.
//  - Stall: out_stall freezes the output stage; upstream stages keep moving
//    into empty slots, so bubbles close up. in_stall rises only once all six
//    stages hold a word, and the words are held intact, none lost or doubled.
//  - Reset (rst, synchronous, active high) empties the pipeline; no words
//    are presented until new ones are accepted. There is no other state.
`default_nettype none

`include "epoch_seconds_to_calendar_macros.svh"

module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] epoch_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [11:0]      year,
  output logic [3:0]       month,
  output logic [4:0]       day_of_month,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic [2:0]       weekday
);

  esc_pkg::pipe_ctrl_t ctrl;
  logic [15:0]         day_num;
  logic [16:0]         day_sec;
  logic                in_take;
  logic                out_take;
  logic [2:0]          fill;
  logic                cal_ok;

  // Valid bits and per-stage load enables.
  esc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  // Stages 1-2: days since epoch and seconds of the day.
  esc_day_split u_split (
    .clk           (clk),
    .ctrl          (ctrl),
    .epoch_seconds (epoch_seconds),
    .day_num       (day_num),
    .day_sec       (day_sec)
  );

  // Stages 3-6: Gregorian year, month, day of month.
  esc_date u_date (
    .clk          (clk),
    .ctrl         (ctrl),
    .day_num      (day_num),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month)
  );

  // Stages 3-6: time of day and weekday, running alongside the date path.
  esc_time u_time (
    .clk     (clk),
    .ctrl    (ctrl),
    .day_num (day_num),
    .day_sec (day_sec),
    .hour    (hour),
    .minute  (minute),
    .second  (second),
    .weekday (weekday)
  );

  // Handshakes and occupancy, for the checks below.
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign fill     = 3'($countones(ctrl.valid));
  assign cal_ok   = (month >= 4'd1) && (month <= 4'd12) && (day_of_month != 5'd0)
                 && (weekday != 3'd0) && (hour <= 5'd23);

  // The input is only held off when every stage is occupied.
  `ESC_ASSERT_IMPL(a_stall_only_full, in_stall, (&ctrl.valid))
  // A word in with none out adds exactly one word to the pipeline.
  `ESC_ASSERT_NEXT(a_fill_count, (in_take && !out_take), (fill == $past(fill) + 3'd1))
  // A word out with none in removes exactly one.
  `ESC_ASSERT_NEXT(a_drain_count, (!in_take && out_take), (fill + 3'd1 == $past(fill)))
  // Presented results are calendar values.
  `ESC_ASSERT_IMPL(a_result_range, out_valid, cal_ok)

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking bench for the epoch seconds to calendar converter.
// Needs only the RTL: epoch_seconds_to_calendar and what it pulls in.
// Directed table, then random stamps, each checked against a typed answer or local predictor.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One calendar breakdown, laid out in the order of the output ports.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } calendar_t;

  // A timestamp to send. Where fixed is set, want holds the answer typed in
  // by hand. Otherwise the predictor supplies it.
  typedef struct packed {
    logic [31:0] secs;
    logic        fixed;
    calendar_t   want;
  } stamp_row_t;

  // Idling schedule. The sender and the receiver swap their duty, then neither idles.
  typedef enum logic [1:0] {
    SRC32_SNK84,
    SRC84_SNK32,
    NO_IDLE
  } idle_mode_t;

  localparam int unsigned SECS_DAY    = 32'd86400;
  localparam int unsigned EPOCH_DAY   = 32'd719163;  // 1970-01-01 counted from year zero
  localparam int unsigned MAR_SHIFT   = 32'd305;
  localparam int unsigned CYCLE_400Y  = 32'd146097;
  localparam int unsigned CYCLE_100Y  = 32'd36524;
  localparam int unsigned CYCLE_4Y    = 32'd1461;
  localparam int unsigned CYCLE_1Y    = 32'd365;
  localparam int unsigned SECS_HOUR   = 32'd3600;

  localparam int RANDOM_WORDS  = 950;
  localparam int HOLD_CYCLES   = 80;    // long receiver hold-off, fills all six stages
  localparam int DRAIN_CYCLES  = 12;    // six-stage latency, twice over
  localparam int STUCK_LIMIT   = 2000;  // cycles with no handshake on either side

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] epoch_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;

  epoch_seconds_to_calendar i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .epoch_seconds(epoch_seconds),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Directed table: the ends of the input range, midnight either side,
  // the Jan/Feb move into the next year, the last day of a 4-year cycle,
  // and the last day of a 400-year cycle (2000-02-29). Only the obvious
  // answers are typed in. The remaining rows go through the predictor.
  stamp_row_t directed_rows [24] = '{
    '{32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0,  3'd2}},
    '{32'd4294967295, 1'b1, '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15, 3'd5}},
    '{32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59, 3'd2}},
    '{32'd86400,      1'b1, '{12'd1970, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0,  3'd3}},
    '{32'd5097599,    1'b0, '0},   // 1970-02-28, end of a March-based year
    '{32'd5097600,    1'b0, '0},   // 1970-03-01
    '{32'd31535999,   1'b0, '0},   // last second of 1970
    '{32'd31536000,   1'b0, '0},
    '{32'd68169600,   1'b0, '0},   // 1972-02-29, year step clamped
    '{32'd68255999,   1'b0, '0},
    '{32'd68256000,   1'b0, '0},
    '{32'd825551999,  1'b0, '0},
    '{32'd825638400,  1'b0, '0},
    '{32'd946684799,  1'b0, '0},
    '{32'd946684800,  1'b0, '0},
    '{32'd951782400,  1'b0, '0},   // 2000-02-29, century step clamped
    '{32'd951868799,  1'b0, '0},
    '{32'd951868800,  1'b0, '0},   // 2000-03-01
    '{32'd2147483647, 1'b0, '0},
    '{32'd2147483648, 1'b0, '0},
    '{32'd4107542399, 1'b0, '0},   // 2100-02-28, no leap day that century
    '{32'd4107542400, 1'b0, '0},
    '{32'h55555555,   1'b0, '0},
    '{32'hAAAAAAAA,   1'b0, '0}
  };

  stamp_row_t  stamp_q[$];     // every word to send, in order
  calendar_t   calendar_q[$];  // breakdowns still owed by the block
  idle_mode_t  mode = SRC32_SNK84;
  int          words_in = 0;
  int          words_out = 0;
  int          mismatches = 0;
  int          stuck_cycles = 0;

  // Gregorian breakdown. Years start on March 1 and are taken apart through
  // the 400/100/4/1 cycles. The 100 and 1 year quotients stop at 3.
  function automatic calendar_t calendar_of(input logic [31:0] secs);
    int unsigned days, dsec, d, q400, r, q100, q4, q1, yr, m, mstart, hr, rest;
    calendar_t   c;
    days = secs / SECS_DAY + EPOCH_DAY;
    dsec = secs % SECS_DAY;
    d    = days + MAR_SHIFT;
    q400 = d / CYCLE_400Y;
    r    = d % CYCLE_400Y;
    q100 = r / CYCLE_100Y;
    if (q100 > 3) q100 = 3;
    r    = r - q100 * CYCLE_100Y;
    q4   = r / CYCLE_4Y;
    r    = r % CYCLE_4Y;
    q1   = r / CYCLE_1Y;
    if (q1 > 3) q1 = 3;
    r    = r - q1 * CYCLE_1Y;
    yr   = q400 * 400 + q100 * 100 + q4 * 4 + q1;
    // Month index 3..14 by the 306/10 rule. 13 and 14 are Jan and Feb of the next year.
    m      = (5 * r + 2) / 153 + 3;
    mstart = 306 * (m + 1) / 10 - 122;
    c.mday = 5'(r - mstart + 1);
    if (m > 12) begin
      m  = m - 12;
      yr = yr + 1;
    end
    hr        = dsec / SECS_HOUR;
    rest      = dsec - hr * SECS_HOUR;
    c.year    = 12'(yr);
    c.month   = 4'(m);
    c.hour    = 5'(hr);
    c.minute  = 6'(rest / 60);
    c.second  = 6'(rest % 60);
    c.weekday = 3'((days + 4) % 7 + 1);
    return c;
  endfunction

  // Random timestamps: mostly uniform, some on day boundaries, some near the ends of the range.
  function automatic logic [31:0] random_stamp();
    int unsigned pick, day;
    longint unsigned s;
    pick = $urandom_range(9);
    if (pick < 6) return $urandom;
    if (pick < 8) begin
      day = $urandom_range(49710);
      s   = longint'(day) * SECS_DAY + ($urandom_range(1) ? 86399 : 0);
      if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
      return s[31:0];
    end
    if (pick == 8) return 32'hFFFF_FFFF - $urandom_range(100000);
    return $urandom_range(100000);
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] word %0d: %s", $realtime, words_out, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Sender: one word at a time. Valid is raised at a falling edge and held,
  // with the payload steady, until a rising edge takes the word.
  initial begin : sender
    int n;
    foreach (directed_rows[k]) stamp_q.push_back(directed_rows[k]);
    repeat (RANDOM_WORDS) stamp_q.push_back('{random_stamp(), 1'b0, '0});
    n = stamp_q.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < n; i++) begin
      @(negedge clk);
      mode = (i < n / 3) ? SRC32_SNK84 : (i < 2 * n / 3) ? SRC84_SNK32 : NO_IDLE;
      while (roll(mode == SRC32_SNK84 ? 32 : mode == SRC84_SNK32 ? 84 : 0)) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
      in_valid      <= 1'b1;
      epoch_seconds <= stamp_q[i].secs;
      do @(posedge clk); while (!(in_valid && !in_stall));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait until every breakdown is in, then give the pipeline
    // a few more cycles to show up any word it should not produce.
    while (calendar_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (calendar_q.size() != 0) begin
      void'(calendar_q.pop_front());
      report_mismatch("expected word never arrived");
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: stalls at random. On entry to the no-idle stretch it holds off
  // for a long while, so the six stages fill up and in_stall has to rise.
  initial begin : receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && mode == NO_IDLE) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= roll(mode == SRC32_SNK84 ? 84 : mode == SRC84_SNK32 ? 32 : 0);
      end
    end
  end

  // Monitor: both handshakes are sampled at the rising edge. A result
  // cannot be the word accepted on the same edge, so the pop comes first.
  always @(posedge clk) begin : monitor
    calendar_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (calendar_q.size() == 0) begin
          report_mismatch("result word with nothing pending");
        end else begin
          want = calendar_q.pop_front();
          check_field("year",         year,         want.year);
          check_field("month",        month,        want.month);
          check_field("day_of_month", day_of_month, want.mday);
          check_field("hour",         hour,         want.hour);
          check_field("minute",       minute,       want.minute);
          check_field("second",       second,       want.second);
          check_field("weekday",      weekday,      want.weekday);
        end
        words_out++;
      end
      if (in_valid && !in_stall) begin
        if (stamp_q[words_in].fixed)
          calendar_q.push_back(stamp_q[words_in].want);
        else
          calendar_q.push_back(calendar_of(epoch_seconds));
        words_in++;
      end
    end
  end

  // Watchdog: ends the run if neither side has moved a word for too long.
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, STUCK_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
